### design/mdss_pkg.sv
package mdss_pkg;

   // default sizes
   localparam int ROWS_DEF     = 8;
   localparam int STEPS_DEF    = 16;
   localparam int PATTERNS_DEF = 8;
   localparam int SLOTS_DEF    = 16;

   localparam int MAX_DURATION   = 32;
   localparam int TICKS_PER_UNIT = 4;
   localparam int MAX_STEP_UNITS = 16;

   localparam logic [4:0] STEP_LENGTH_RST     = 5'd4;
   localparam logic [3:0] MIDI_CHANNEL_RST    = 4'd1;
   localparam logic [4:0] SEQUENCE_LENGTH_RST = 5'd4;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_START      = 3'd1,
      OP_STOP       = 3'd2,
      OP_RESET      = 3'd3,
      OP_WRITE_CELL = 3'd4,
      OP_WRITE_SLOT = 3'd5,
      OP_WRITE_ROW  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      CSR_STEP_LENGTH     = 2'd0,
      CSR_MIDI_CHANNEL    = 2'd1,
      CSR_SEQUENCE_LENGTH = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL_RD,
      ST_CELL_WR,
      ST_SEQ_RD,
      ST_PAT_RD,
      ST_PLAY,
      ST_RELEASE,
      ST_FINISH
   } st_type;

   typedef enum logic [1:0] {
      HC_NONE,
      HC_TRIGGER,
      HC_COUNT
   } held_cmd_type;

   // what the row unit reports for the selected row
   typedef struct packed {
      logic [6:0] note;
      logic [6:0] velocity;
      logic       active;
      logic [3:0] held_ch;
      logic [6:0] held_note;
      logic       retrig_off;
      logic       cd_zero;
   } row_view_type;

   typedef struct packed {
      logic [6:0] velocity;
      logic [6:0] note;
      logic [3:0] channel;
   } msg_type;

endpackage

### design/midi_drum_step_sequencer_core.sv
// Channel  Dir  Handshake              Contents
// req      in   req_tvalid/req_tready  tuser: operation; tdata: command fields
// rsp      out  rsp_tvalid/rsp_tready  tdata: note message; tlast: last of tick
// csr      in   csr_we                 csr_index, csr_wdata
//
// A tick at the start of a step reads the chain and then the pattern memory while
// running, then makes a pass over the rows for note-ons (a re-triggered row first
// sends a note-off) and one for countdowns, all through a single row unit; stopped,
// it makes only the countdown pass. A cell write reads, then writes a pattern word.
// A stalled rsp side holds the row walk. After reset a clearing pass over every
// address zeroes the pattern and chain memories; req_tready stays low until done.
module midi_drum_step_sequencer_core #(
   parameter int ROWS     = mdss_pkg::ROWS_DEF,
   parameter int STEPS    = mdss_pkg::STEPS_DEF,
   parameter int PATTERNS = mdss_pkg::PATTERNS_DEF,
   parameter int SLOTS    = mdss_pkg::SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pattern_index, step_index, row_index, cell_on, slot_index,
   // note_number, note_velocity, note_duration
   input  logic [39:0] req_tdata,
   // operation
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // channel_out, note_out, velocity_out
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SW        = $clog2(STEPS);
   localparam int PW        = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
   localparam int QW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PDEPTH    = PATTERNS * STEPS;
   localparam int AW        = $clog2(PDEPTH);
   localparam int CLR_DEPTH = (PDEPTH > SLOTS) ? PDEPTH : SLOTS;
   localparam int CLRW      = $clog2(CLR_DEPTH);
   localparam int LENW      = ($clog2(SLOTS + 1) > 5) ? $clog2(SLOTS + 1) : 5;

   // request fields
   logic [2:0] f_pat;
   logic [3:0] f_step;
   logic [2:0] f_row;
   logic       f_cell;
   logic [3:0] f_slot;
   logic [6:0] f_note;
   logic [6:0] f_vel;
   logic [5:0] f_dur;
   mdss_pkg::op_type f_op;

   assign f_pat  = req_tdata[2:0];
   assign f_step = req_tdata[6:3];
   assign f_row  = req_tdata[9:7];
   assign f_cell = req_tdata[10];
   assign f_slot = req_tdata[14:11];
   assign f_note = req_tdata[21:15];
   assign f_vel  = req_tdata[28:22];
   assign f_dur  = req_tdata[34:29];
   assign f_op   = mdss_pkg::op_type'(req_tuser);

   mdss_pkg::st_type state_ff, state_in;

   logic [5:0]      tick_ff, tick_in;
   logic [SW-1:0]   step_ff, step_in;
   logic [QW-1:0]   slot_ff, slot_in;
   logic            run_ff, run_in;
   logic            keep_ff, keep_in;
   logic [RW-1:0]   row_ff, row_in;
   logic            off_done_ff, off_done_in;
   logic [CLRW-1:0] clr_ff, clr_in;
   logic [AW-1:0]   cw_addr_ff, cw_addr_in;
   logic [RW-1:0]   cw_row_ff, cw_row_in;
   logic            cw_on_ff, cw_on_in;

   logic [4:0] step_len_ff;
   logic [3:0] chan_ff;
   logic [4:0] seq_len_ff;

   logic              pend_valid_ff, pend_valid_in;
   mdss_pkg::msg_type pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   mdss_pkg::msg_type out_ff, out_in;
   logic              out_last_ff, out_last_in;

   logic              out_free;
   logic              can_emit;
   logic              emit_req;
   mdss_pkg::msg_type emit_msg;
   logic              flush_req;

   // memory ports
   logic            pat_we, pat_re;
   logic [AW-1:0]   pat_waddr, pat_raddr;
   logic [ROWS-1:0] pat_wdata, pat_rdata, cw_mask;
   logic            seq_we, seq_re;
   logic [QW-1:0]   seq_waddr, seq_raddr;
   logic [PW-1:0]   seq_wdata, seq_rdata;

   // row unit
   logic                   set_we;
   mdss_pkg::held_cmd_type held_cmd;
   mdss_pkg::row_view_type view;

   // step timing
   logic [4:0]      units;
   logic [6:0]      terminal;
   logic [6:0]      tick_plus;
   logic [LENW-1:0] seq_len;
   logic [LENW-1:0] slot_plus;

   logic req_accept;
   logic stopping;

   mdss_ram #(.WIDTH(ROWS), .DEPTH(PDEPTH)) u_pat_ram (
      .clock (clock),
      .we    (pat_we),
      .waddr (pat_waddr),
      .wdata (pat_wdata),
      .re    (pat_re),
      .raddr (pat_raddr),
      .rdata (pat_rdata)
   );

   mdss_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_seq_ram (
      .clock (clock),
      .we    (seq_we),
      .waddr (seq_waddr),
      .wdata (seq_wdata),
      .re    (seq_re),
      .raddr (seq_raddr),
      .rdata (seq_rdata)
   );

   mdss_rows #(.ROWS(ROWS)) u_rows (
      .clock    (clock),
      .reset    (reset),
      .set_we   (set_we),
      .set_row  (RW'(f_row)),
      .set_note (f_note),
      .set_vel  (f_vel),
      .set_dur  (f_dur),
      .sel_row  (row_ff),
      .channel  (chan_ff),
      .cmd      (held_cmd),
      .view     (view)
   );

   assign req_tready = (state_ff == mdss_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign out_free = !out_valid_ff || rsp_tready;
   // a new message pushes the pending one out, so both slots must allow it
   assign can_emit = !pend_valid_ff || out_free;
   assign flush_req = (state_ff == mdss_pkg::ST_FINISH);

   assign cw_mask = ROWS'(1) << cw_row_ff;
   assign stopping = (step_ff == '0) && !keep_ff;

   always_comb begin
      units = step_len_ff;
      if (step_len_ff == 5'd0) begin
         units = 5'd1;
      end else if (step_len_ff > 5'(mdss_pkg::MAX_STEP_UNITS)) begin
         units = 5'(mdss_pkg::MAX_STEP_UNITS);
      end
      terminal  = 7'(units * mdss_pkg::TICKS_PER_UNIT);
      tick_plus = {1'b0, tick_ff} + 7'd1;

      seq_len = LENW'(seq_len_ff);
      if (seq_len == '0) begin
         seq_len = LENW'(1);
      end else if (seq_len > LENW'(SLOTS)) begin
         seq_len = LENW'(SLOTS);
      end
      slot_plus = LENW'(slot_ff) + LENW'(1);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      tick_in     = tick_ff;
      step_in     = step_ff;
      slot_in     = slot_ff;
      run_in      = run_ff;
      keep_in     = keep_ff;
      row_in      = row_ff;
      off_done_in = off_done_ff;
      clr_in      = clr_ff;
      cw_addr_in  = cw_addr_ff;
      cw_row_in   = cw_row_ff;
      cw_on_in    = cw_on_ff;

      pat_we    = 1'b0;
      pat_waddr = cw_addr_ff;
      pat_wdata = '0;
      pat_re    = 1'b0;
      pat_raddr = cw_addr_ff;
      seq_we    = 1'b0;
      seq_waddr = QW'(f_slot);
      seq_wdata = PW'(f_pat);
      seq_re    = 1'b0;
      seq_raddr = slot_ff;
      set_we    = 1'b0;
      held_cmd  = mdss_pkg::HC_NONE;
      emit_req  = 1'b0;
      emit_msg  = '{velocity: 7'd0, note: view.held_note, channel: view.held_ch};

      unique case (state_ff)
         mdss_pkg::ST_CLEAR: begin
            pat_we    = (int'(clr_ff) < PDEPTH);
            pat_waddr = clr_ff[AW-1:0];
            seq_we    = (int'(clr_ff) < SLOTS);
            seq_waddr = clr_ff[QW-1:0];
            seq_wdata = '0;
            clr_in    = clr_ff + CLRW'(1);
            if (clr_ff == CLRW'(CLR_DEPTH - 1)) begin
               state_in = mdss_pkg::ST_IDLE;
            end
         end

         mdss_pkg::ST_IDLE: begin
            if (req_accept) begin
               row_in      = '0;
               off_done_in = 1'b0;
               unique case (f_op)
                  mdss_pkg::OP_TICK: begin
                     if (tick_ff == '0) begin
                        if (stopping) begin
                           run_in  = 1'b0;
                           keep_in = 1'b0;
                           step_in = '0;
                           slot_in = '0;
                        end
                        state_in = (run_ff && !stopping) ? mdss_pkg::ST_SEQ_RD :
                                                           mdss_pkg::ST_RELEASE;
                     end else begin
                        state_in = mdss_pkg::ST_FINISH;
                     end
                  end
                  mdss_pkg::OP_START: begin
                     run_in  = 1'b1;
                     keep_in = 1'b1;
                  end
                  mdss_pkg::OP_STOP: begin
                     keep_in = 1'b0;
                  end
                  mdss_pkg::OP_RESET: begin
                     run_in  = 1'b0;
                     keep_in = 1'b0;
                     step_in = '0;
                     slot_in = '0;
                     tick_in = '0;
                  end
                  mdss_pkg::OP_WRITE_CELL: begin
                     if (int'(f_pat) < PATTERNS && int'(f_step) < STEPS &&
                         int'(f_row) < ROWS) begin
                        cw_addr_in = AW'(int'(f_pat) * STEPS + int'(f_step));
                        cw_row_in  = RW'(f_row);
                        cw_on_in   = f_cell;
                        state_in   = mdss_pkg::ST_CELL_RD;
                     end
                  end
                  mdss_pkg::OP_WRITE_SLOT: begin
                     seq_we = (int'(f_slot) < SLOTS) && (int'(f_pat) < PATTERNS);
                  end
                  mdss_pkg::OP_WRITE_ROW: begin
                     set_we = (int'(f_row) < ROWS);
                  end
                  default: begin
                  end
               endcase
            end
         end

         mdss_pkg::ST_CELL_RD: begin
            pat_re   = 1'b1;
            state_in = mdss_pkg::ST_CELL_WR;
         end

         mdss_pkg::ST_CELL_WR: begin
            pat_we    = 1'b1;
            pat_wdata = cw_on_ff ? (pat_rdata | cw_mask) : (pat_rdata & ~cw_mask);
            state_in  = mdss_pkg::ST_IDLE;
         end

         mdss_pkg::ST_SEQ_RD: begin
            seq_re   = 1'b1;
            state_in = mdss_pkg::ST_PAT_RD;
         end

         mdss_pkg::ST_PAT_RD: begin
            pat_re    = 1'b1;
            pat_raddr = AW'(int'(seq_rdata) * STEPS + int'(step_ff));
            state_in  = mdss_pkg::ST_PLAY;
         end

         mdss_pkg::ST_PLAY: begin
            if (!pat_rdata[row_ff]) begin
               row_in = row_ff + RW'(1);
               if (row_ff == RW'(ROWS - 1)) begin
                  row_in   = '0;
                  state_in = mdss_pkg::ST_RELEASE;
               end
            end else if (view.retrig_off && !off_done_ff) begin
               // release the old note of this row first
               emit_req = 1'b1;
               if (can_emit) begin
                  off_done_in = 1'b1;
               end
            end else begin
               emit_req = 1'b1;
               emit_msg = '{velocity: view.velocity, note: view.note, channel: chan_ff};
               if (can_emit) begin
                  held_cmd    = mdss_pkg::HC_TRIGGER;
                  off_done_in = 1'b0;
                  row_in      = row_ff + RW'(1);
                  if (row_ff == RW'(ROWS - 1)) begin
                     row_in   = '0;
                     state_in = mdss_pkg::ST_RELEASE;
                  end
               end
            end
         end

         mdss_pkg::ST_RELEASE: begin
            emit_req = view.active && view.cd_zero;
            if (!emit_req || can_emit) begin
               if (view.active) begin
                  held_cmd = mdss_pkg::HC_COUNT;
               end
               row_in = row_ff + RW'(1);
               if (row_ff == RW'(ROWS - 1)) begin
                  row_in   = '0;
                  state_in = mdss_pkg::ST_FINISH;
               end
            end
         end

         mdss_pkg::ST_FINISH: begin
            if (can_emit) begin
               state_in = mdss_pkg::ST_IDLE;
               if (tick_plus >= terminal) begin
                  tick_in = '0;
                  if (run_ff) begin
                     step_in = step_ff + SW'(1);
                     if (step_ff == SW'(STEPS - 1)) begin
                        step_in = '0;
                        slot_in = (slot_plus >= seq_len) ? '0 : QW'(slot_plus);
                     end
                  end
               end else begin
                  tick_in = tick_plus[5:0];
               end
            end
         end

         default: begin
            state_in = mdss_pkg::ST_IDLE;
         end
      endcase
   end

   // one message is held back so the last one of a tick can be marked
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (emit_req && can_emit) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = emit_msg;
      end else if (flush_req && pend_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mdss_pkg::ST_CLEAR;
         tick_ff       <= '0;
         step_ff       <= '0;
         slot_ff       <= '0;
         run_ff        <= 1'b0;
         keep_ff       <= 1'b0;
         row_ff        <= '0;
         off_done_ff   <= 1'b0;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         step_len_ff   <= mdss_pkg::STEP_LENGTH_RST;
         chan_ff       <= mdss_pkg::MIDI_CHANNEL_RST;
         seq_len_ff    <= mdss_pkg::SEQUENCE_LENGTH_RST;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         step_ff       <= step_in;
         slot_ff       <= slot_in;
         run_ff        <= run_in;
         keep_ff       <= keep_in;
         row_ff        <= row_in;
         off_done_ff   <= off_done_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_we) begin
            unique case (mdss_pkg::csr_type'(csr_index))
               mdss_pkg::CSR_STEP_LENGTH:     step_len_ff <= csr_wdata;
               mdss_pkg::CSR_MIDI_CHANNEL:    chan_ff     <= csr_wdata[3:0];
               mdss_pkg::CSR_SEQUENCE_LENGTH: seq_len_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cw_addr_ff  <= cw_addr_in;
      cw_row_ff   <= cw_row_in;
      cw_on_ff    <= cw_on_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.velocity, out_ff.note, out_ff.channel};
   assign rsp_tlast  = out_last_ff;

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mdss_pkg::ST_CLEAR) |-> !rsp_tvalid)
      else $error("message during clearing pass");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mdss_pkg::ST_IDLE) |-> !pend_valid_ff)
      else $error("held-back message left at end of tick");

   a_flush_marks_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mdss_pkg::ST_FINISH && pend_valid_ff && out_free)
      |=> (rsp_tvalid && rsp_tlast))
      else $error("final message of tick not marked last");

   a_keep_implies_run: assert property (@(posedge clock) disable iff (reset)
      keep_ff |-> run_ff)
      else $error("keep_running set while stopped");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mdss_pkg::ST_PLAY || state_ff == mdss_pkg::ST_RELEASE)
      |-> (int'(row_ff) < ROWS))
      else $error("row counter out of range");

endmodule

### design/mdss_ram.sv
module mdss_ram #(
   parameter int WIDTH = mdss_pkg::ROWS_DEF,
   parameter int DEPTH = mdss_pkg::PATTERNS_DEF * mdss_pkg::STEPS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/mdss_rows.sv
module mdss_rows #(
   parameter int ROWS = mdss_pkg::ROWS_DEF,
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       set_we,
   input  logic [RW-1:0]              set_row,
   input  logic [6:0]                 set_note,
   input  logic [6:0]                 set_vel,
   input  logic [5:0]                 set_dur,
   input  logic [RW-1:0]              sel_row,
   input  logic [3:0]                 channel,
   input  mdss_pkg::held_cmd_type     cmd,
   output mdss_pkg::row_view_type     view
);

   logic [6:0]      note_ff  [ROWS];
   logic [6:0]      vel_ff   [ROWS];
   logic [5:0]      dur_ff   [ROWS];
   logic [ROWS-1:0] active_ff;
   logic [3:0]      hch_ff   [ROWS];
   logic [6:0]      hnote_ff [ROWS];
   logic [5:0]      cd_ff    [ROWS];

   logic       active_in;
   logic [3:0] hch_in;
   logic [6:0] hnote_in;
   logic [5:0] cd_in;
   logic [5:0] dur_sat;
   logic       cd_zero;

   assign dur_sat = (set_dur > 6'(mdss_pkg::MAX_DURATION)) ?
                    6'(mdss_pkg::MAX_DURATION) : set_dur;

   // shared compare / decrement unit, applied to one row per cycle
   assign cd_zero = (cd_ff[sel_row] == 6'd0);

   always_comb begin
      active_in = active_ff[sel_row];
      hch_in    = hch_ff[sel_row];
      hnote_in  = hnote_ff[sel_row];
      cd_in     = cd_ff[sel_row];
      unique case (cmd)
         mdss_pkg::HC_TRIGGER: begin
            active_in = 1'b1;
            hch_in    = channel;
            hnote_in  = note_ff[sel_row];
            cd_in     = dur_ff[sel_row];
         end
         mdss_pkg::HC_COUNT: begin
            active_in = !cd_zero;
            if (!cd_zero) begin
               cd_in = cd_ff[sel_row] - 6'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      view.note       = note_ff[sel_row];
      view.velocity   = vel_ff[sel_row];
      view.active     = active_ff[sel_row];
      view.held_ch    = hch_ff[sel_row];
      view.held_note  = hnote_ff[sel_row];
      view.retrig_off = active_ff[sel_row] &&
                        ((hch_ff[sel_row] != channel) || (hnote_ff[sel_row] != note_ff[sel_row]));
      view.cd_zero    = cd_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS; i++) begin
            note_ff[i] <= '0;
            vel_ff[i]  <= '0;
            dur_ff[i]  <= '0;
         end
         active_ff <= '0;
      end else begin
         if (set_we) begin
            note_ff[set_row] <= set_note;
            vel_ff[set_row]  <= set_vel;
            dur_ff[set_row]  <= dur_sat;
         end
         if (cmd != mdss_pkg::HC_NONE) begin
            active_ff[sel_row] <= active_in;
            hch_ff[sel_row]    <= hch_in;
            hnote_ff[sel_row]  <= hnote_in;
            cd_ff[sel_row]     <= cd_in;
         end
      end
   end

endmodule
